/* design/b64enc_pkg.sv */
// Package for the base64 stream encoder: the group entry type and the
// alphabet lookup. It depends on nothing; all encoder modules use it.
`default_nettype none

package b64enc_pkg;

    // ASCII code of the padding character.
    localparam logic [6:0] PAD_CHAR = 7'd61;

    // Number of characters in one encoded group.
    localparam int GroupChars = 4;

    // One group, ready to be turned into four characters.
    typedef struct packed {
        logic [23:0] bits;    // Three bytes, the oldest in bits 23..16.
        logic [1:0]  pad;     // Trailing '=' characters: 0, 1 or 2.
        logic        last;    // The fourth character ends the stream.
    } t_group;

    // Fill state of the group queue, as seen by its two sides.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // Maps a six-bit value to its character of the standard alphabet.
    function automatic logic [6:0] sextet_char(input logic [5:0] s);
        logic [6:0] c;
        case (s) inside
            [6'd0 : 6'd25]:  c = 7'd65 + {1'b0, s};
            [6'd26 : 6'd51]: c = 7'd71 + {1'b0, s};
            [6'd52 : 6'd61]: c = {1'b0, s} - 7'd4;
            6'd62:           c = 7'd43;
            default:         c = 7'd47;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/b64enc_front.sv */
// Front end of the encoder: accepts bytes, holds up to two pending bytes
// and pushes a complete or flushed group into the queue. Uses b64enc_pkg.
`default_nettype none

module b64enc_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  [7:0]            i_data_byte,
    input  wire                   i_final_byte,
    input  b64enc_pkg::t_q_stat   i_q_stat,
    output logic                  o_push,
    output b64enc_pkg::t_group    o_entry
);

    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic [15:0] r_pending;
    logic [15:0] n_pending;
    logic        accept;
    logic        full_group;

    // A byte is taken whenever the queue has room for a possible group.
    assign o_ready    = !i_q_stat.full;
    assign accept     = i_valid && o_ready;
    // A count above two is treated as two.
    assign full_group = r_count[1];

    // Build the group entry and the next pending state.
    always_comb begin
        n_count       = r_count;
        n_pending     = r_pending;
        o_push        = 1'b0;
        o_entry.bits  = {r_pending, i_data_byte};
        o_entry.pad   = 2'd0;
        o_entry.last  = i_final_byte;
        if (full_group) begin
            o_entry.bits = {r_pending, i_data_byte};
            o_entry.pad  = 2'd0;
        end else if (r_count == 2'd1) begin
            o_entry.bits = {r_pending[7:0], i_data_byte, 8'h00};
            o_entry.pad  = 2'd1;
        end else begin
            o_entry.bits = {i_data_byte, 16'h0000};
            o_entry.pad  = 2'd2;
        end
        if (accept) begin
            if (full_group || i_final_byte) begin
                o_push    = 1'b1;
                n_count   = 2'd0;
                n_pending = 16'h0000;
            end else begin
                n_count   = r_count + 2'd1;
                n_pending = {r_pending[7:0], i_data_byte};
            end
        end
    end

    // Pending byte state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 2'd0;
            r_pending <= 16'h0000;
        end else begin
            r_count   <= n_count;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

/* design/b64enc_queue.sv */
// Short queue of group entries between the front and back ends of the
// encoder. Uses the entry and status types of b64enc_pkg.
`default_nettype none

module b64enc_queue #(
    parameter int DEPTH = 2
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  b64enc_pkg::t_group    i_entry,
    input  wire                   i_pop,
    output b64enc_pkg::t_group    o_entry,
    output b64enc_pkg::t_q_stat   o_stat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    b64enc_pkg::t_group r_mem [DEPTH];
    logic [PtrW-1:0]    r_wr_ptr;
    logic [PtrW-1:0]    r_rd_ptr;
    logic [CntW-1:0]    r_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CntW'(DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_entry      = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/b64enc_back.sv */
// Back end of the encoder: takes group entries from the queue and sends
// their four characters, one per cycle while the output is read, through an output register.
// Uses the types and the alphabet function of b64enc_pkg.
`default_nettype none

module b64enc_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  b64enc_pkg::t_q_stat   i_q_stat,
    input  b64enc_pkg::t_group    i_entry,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [6:0]            o_code_char,
    output logic                  o_last_char
);

    localparam logic [1:0] LastIdx = 2'(b64enc_pkg::GroupChars - 1);

    b64enc_pkg::t_group r_grp;
    logic               r_busy;
    logic [1:0]         r_idx;
    logic               r_out_valid;
    logic [6:0]         r_char;
    logic               r_last;
    logic               out_free;
    logic               advance;
    logic [5:0]         sextet;
    logic               is_pad;
    logic [6:0]         next_char;

    assign o_valid     = r_out_valid;
    assign o_code_char = r_char;
    assign o_last_char = r_last;

    // The output register can take a character when empty or being read.
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_busy && out_free;
    assign o_pop    = !i_q_stat.empty && (!r_busy || (advance && r_idx == LastIdx));

    // Select the sextet of the current character, most significant first.
    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_grp.bits[23:18];
            2'd1:    sextet = r_grp.bits[17:12];
            2'd2:    sextet = r_grp.bits[11:6];
            default: sextet = r_grp.bits[5:0];
        endcase
        is_pad    = ({1'b0, r_idx} + {1'b0, r_grp.pad}) > {1'b0, LastIdx};
        next_char = is_pad ? b64enc_pkg::PAD_CHAR : b64enc_pkg::sextet_char(sextet);
    end

    // Group sequencing and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + 2'd1;
                if (r_idx == LastIdx) begin
                    r_busy <= 1'b0;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_char <= next_char;
            r_last <= r_grp.last && (r_idx == LastIdx);
        end
        if (o_pop) begin
            r_grp <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* design/base64_stream_encoder.sv */
// Base64 stream encoder, standard alphabet with '=' padding.
// A completing byte pushes its group into the queue, whence it moves to
// the back end's group register and its first character to the output
// register. Throughput: one character per cycle while the output is read,
// set by the single output register. Reset is synchronous and active low;
// it empties the pending bytes, the group queue and the output register.
`default_nettype none

module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_final_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [6:0]  o_code_char,
    output logic        o_last_char
);

    b64enc_pkg::t_q_stat q_stat;
    b64enc_pkg::t_group  push_entry;
    b64enc_pkg::t_group  head_entry;
    logic                push;
    logic                pop;

    // Byte intake and grouping.
    b64enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // Queue of pending groups.
    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (q_stat)
    );

    // Character generation.
    b64enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_entry     (head_entry),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_code_char (o_code_char),
        .o_last_char (o_last_char)
    );

endmodule

`default_nettype wire
